>>> hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// condition that must never hold while out of reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

>>> hdl/lef_pkg.sv
// shared constants and types of the laplacian edge filter
package lef_pkg;

   localparam int unsigned MAX_WIDTH = 2048;
   localparam int unsigned COL_BITS  = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_BITS  = 12;
   localparam int unsigned PIX_BITS  = 8;
   localparam int unsigned CSR_BITS  = 12;
   localparam int unsigned IDX_BITS  = 2;

   localparam logic [IDX_BITS-1:0] CSR_FRAME_WIDTH  = IDX_BITS'(0);
   localparam logic [IDX_BITS-1:0] CSR_FRAME_HEIGHT = IDX_BITS'(1);

   localparam logic [CSR_BITS-1:0] WIDTH_RESET  = CSR_BITS'(160);
   localparam logic [CSR_BITS-1:0] HEIGHT_RESET = CSR_BITS'(120);
   localparam logic [CSR_BITS-1:0] MIN_SIZE     = CSR_BITS'(3);

   typedef logic [PIX_BITS-1:0] pix_type;

   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] out_y;
      logic                is_result;
      logic                last;
   } pos_type;

endpackage

>>> hdl/lef_ram.sv
// generic single-write, single-read ram with registered read data
module lef_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/lef_position.sv
// size registers, raster position counters and interior classification
module lef_position import lef_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0] csr_data,
   input  logic                accept,
   input  logic                frame_start,
   output pos_type             pos
);

   logic [CSR_BITS-1:0] width_ff, width_in;
   logic [CSR_BITS-1:0] height_ff, height_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;

   logic [CSR_BITS-1:0] eff_w;
   logic [ROW_BITS:0]   eff_h;
   logic [COL_BITS-1:0] c;
   logic [ROW_BITS-1:0] r;
   logic [CSR_BITS:0]   c1, c2;
   logic [ROW_BITS:0]   r1;
   logic                line_end;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_data;
            CSR_FRAME_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (width_ff < MIN_SIZE) begin
         eff_w = MIN_SIZE;
      end else if (width_ff > CSR_BITS'(MAX_WIDTH)) begin
         eff_w = CSR_BITS'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      eff_h = (height_ff < MIN_SIZE) ? (ROW_BITS+1)'(MIN_SIZE) : (ROW_BITS+1)'(height_ff);
   end

   // frame_start puts the pixel at the origin
   assign c  = frame_start ? '0 : col_ff;
   assign r  = frame_start ? '0 : row_ff;
   assign c1 = (CSR_BITS+1)'(c) + (CSR_BITS+1)'(1);
   assign c2 = (CSR_BITS+1)'(c) + (CSR_BITS+1)'(2);
   assign r1 = (ROW_BITS+1)'(r) + (ROW_BITS+1)'(1);
   assign line_end = c1 >= (CSR_BITS+1)'(eff_w);

   always_comb begin
      pos.col       = c;
      pos.out_y     = r - ROW_BITS'(1);
      pos.is_result = (c != '0) && (c2 <= (CSR_BITS+1)'(eff_w))
                      && (r >= ROW_BITS'(2)) && (r1 <= eff_h);
      pos.last      = (c2 == (CSR_BITS+1)'(eff_w)) && (r1 == eff_h);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (line_end) begin
            col_in = '0;
            row_in = (r1 >= eff_h) ? '0 : r1[ROW_BITS-1:0];
         end else begin
            col_in = c1[COL_BITS-1:0];
            row_in = r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

>>> hdl/lef_kernel.sv
// four-neighbour laplacian, clamp and inversion
module lef_kernel import lef_pkg::*; (
   input  pix_type north,
   input  pix_type south,
   input  pix_type east,
   input  pix_type west,
   input  pix_type centre,
   output pix_type edge_value
);

   logic        [PIX_BITS+1:0] nsum;
   logic        [PIX_BITS+1:0] c4;
   logic signed [PIX_BITS+2:0] diff;
   pix_type                    clamped;

   always_comb begin
      nsum = (PIX_BITS+2)'(north) + (PIX_BITS+2)'(south)
             + (PIX_BITS+2)'(east) + (PIX_BITS+2)'(west);
      c4   = {centre, 2'b00};
      diff = $signed({1'b0, nsum}) - $signed({1'b0, c4});
      priority if (diff < 0) begin
         clamped = '0;
      end else if (diff > (PIX_BITS+3)'(255)) begin
         clamped = '1;
      end else begin
         clamped = diff[PIX_BITS-1:0];
      end
      edge_value = ~clamped;
   end

endmodule

>>> hdl/laplacian_edge_filter.sv
// top level of the streaming four-neighbour laplacian edge filter
//
//   channel  direction  handshake               beat contents
//   req      in         req_valid / req_stall   pixel, frame_start
//   rsp      out        rsp_valid / rsp_stall   out_x, out_y, edge_value, last_of_frame
//   csr      in         csr_write_en            csr_index, csr_data
//
// one pixel per cycle while req_stall is low; a result leaves after its south pixel is taken
// (line buffer read, then kernel into the output register)
// the line buffers hold one write and one read port each, east uses a duplicate
// reset is synchronous and clears counters, window and valids, not the buffers
// rsp_stall holds a result in place and backs up req only when it blocks a result
`include "assert_macros.svh"

module laplacian_edge_filter import lef_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [PIX_BITS-1:0] req_pixel,
   input  logic                req_frame_start,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COL_BITS-1:0] rsp_out_x,
   output logic [ROW_BITS-1:0] rsp_out_y,
   output logic [PIX_BITS-1:0] rsp_edge_value,
   output logic                rsp_last_of_frame,
   input  logic                csr_write_en,
   input  logic [IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0] csr_data
);

   logic    accept;
   pos_type pos;

   logic    s1_valid_ff, s1_valid_in;
   pos_type s1_pos_ff;
   pix_type s1_px_ff;
   logic    byp_c_ff, byp_e_ff;
   pix_type byp_px_ff, byp_north_ff;
   pix_type west_ff;

   pix_type one_a_rd, one_b_rd, two_rd;
   pix_type s1_centre, s1_north, s1_east, s1_edge;
   logic    s1_fire, rsp_free;
   logic    byp_c_in, byp_e_in;
   logic [COL_BITS-1:0] east_addr;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COL_BITS-1:0] rsp_x_ff;
   logic [ROW_BITS-1:0] rsp_y_ff;
   pix_type             rsp_edge_ff;
   logic                rsp_last_ff;

   assign accept = req_valid && !req_stall;

   lef_position u_position (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .accept       (accept),
      .frame_start  (req_frame_start),
      .pos          (pos)
   );

   assign east_addr = pos.col + COL_BITS'(1);

   lef_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_one_a (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_pos_ff.col),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (pos.col),
      .rd_data (one_a_rd)
   );

   lef_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_one_b (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_pos_ff.col),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (east_addr),
      .rd_data (one_b_rd)
   );

   lef_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_two (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_pos_ff.col),
      .wr_data (s1_centre),
      .rd_en   (accept),
      .rd_addr (pos.col),
      .rd_data (two_rd)
   );

   // a write leaving s1 on the same edge as a read of that entry is forwarded
   assign s1_centre = byp_c_ff ? byp_px_ff    : one_a_rd;
   assign s1_north  = byp_c_ff ? byp_north_ff : two_rd;
   assign s1_east   = byp_e_ff ? byp_px_ff    : one_b_rd;

   lef_kernel u_kernel (
      .north      (s1_north),
      .south      (s1_px_ff),
      .east       (s1_east),
      .west       (west_ff),
      .centre     (s1_centre),
      .edge_value (s1_edge)
   );

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && (!s1_pos_ff.is_result || rsp_free);
   assign req_stall = s1_valid_ff && !s1_fire;

   assign byp_c_in = s1_fire && (pos.col == s1_pos_ff.col);
   assign byp_e_in = s1_fire && (east_addr == s1_pos_ff.col);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_fire && s1_pos_ff.is_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         west_ff      <= '0;
         byp_c_ff     <= 1'b0;
         byp_e_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            west_ff <= s1_centre;
         end
         if (accept) begin
            byp_c_ff <= byp_c_in;
            byp_e_ff <= byp_e_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff    <= pos;
         s1_px_ff     <= req_pixel;
         byp_px_ff    <= s1_px_ff;
         byp_north_ff <= s1_centre;
      end
      if (s1_fire && s1_pos_ff.is_result) begin
         rsp_x_ff    <= s1_pos_ff.col;
         rsp_y_ff    <= s1_pos_ff.out_y;
         rsp_edge_ff <= s1_edge;
         rsp_last_ff <= s1_pos_ff.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_x         = rsp_x_ff;
   assign rsp_out_y         = rsp_y_ff;
   assign rsp_edge_value    = rsp_edge_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   `ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, req_stall, s1_valid_ff)
   `ASSERT_NEVER(a_bypass_exclusive, clock, reset, s1_valid_ff && byp_c_ff && byp_e_ff)
   `ASSERT_IMPLIES(a_result_is_interior, clock, reset, s1_valid_ff && s1_pos_ff.is_result,
      s1_pos_ff.col != '0 && s1_pos_ff.out_y != '0)
   `ASSERT_IMPLIES(a_result_drains, clock, reset, s1_fire && s1_pos_ff.is_result, rsp_free)

endmodule

>>> test/lef_checker.sv
// checker of the laplacian edge filter: predicts edge results from accepted beats and compares
module lef_checker import lef_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [PIX_BITS-1:0] req_pixel,
   input  logic                req_frame_start,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [COL_BITS-1:0] rsp_out_x,
   input  logic [ROW_BITS-1:0] rsp_out_y,
   input  logic [PIX_BITS-1:0] rsp_edge_value,
   input  logic                rsp_last_of_frame,
   input  logic                csr_write_en,
   input  logic [IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0] csr_data,
   output int                  failures,
   output int                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [COL_BITS-1:0] x;
      logic [ROW_BITS-1:0] y;
      pix_type             value;
      logic                last;
   } edge_result_type;

   edge_result_type edge_results_due[$];

   // the two rows above the incoming pixel
   pix_type row_m1 [MAX_WIDTH];
   pix_type row_m2 [MAX_WIDTH];
   pix_type left_centre;
   int unsigned col_pos;
   int unsigned row_pos;
   logic [CSR_BITS-1:0] cfg_width;
   logic [CSR_BITS-1:0] cfg_height;

   function automatic void filter_pixel(input pix_type px, input logic fs);
      int unsigned w, h, c, r;
      int v;
      pix_type north, centre, east, west;
      edge_result_type res;
      w = (cfg_width < MIN_SIZE) ? 3 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
      h = (cfg_height < MIN_SIZE) ? 3 : cfg_height;
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      west = left_centre;
      north = row_m2[c];
      centre = row_m1[c];
      east = (c + 1 < MAX_WIDTH) ? row_m1[c + 1] : '0;
      // this pixel is the south neighbour of centre (c, r-1)
      if (c >= 1 && c + 2 <= w && r >= 2 && r + 1 <= h) begin
         v = int'(north) + int'(px) + int'(east) + int'(west) - 4 * int'(centre);
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         res.x = COL_BITS'(c);
         res.y = ROW_BITS'(r - 1);
         res.value = pix_type'(255 - v);
         res.last = (c + 2 == w) && (r + 1 == h);
         edge_results_due.push_back(res);
      end
      row_m2[c] = centre;
      row_m1[c] = px;
      left_centre = centre;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic void log_failure(input string what, input edge_result_type want,
                                       input edge_result_type got);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%0t %s: want x=%0d y=%0d value=%0d last=%0b, got x=%0d y=%0d value=%0d last=%0b",
                  $time, what, want.x, want.y, want.value, want.last,
                  got.x, got.y, got.value, got.last);
      end
   endfunction

   always @(posedge clock) begin : watch
      edge_result_type got, want;
      if (reset) begin
         edge_results_due.delete();
         col_pos = 0;
         row_pos = 0;
         left_centre = '0;
         cfg_width = WIDTH_RESET;
         cfg_height = HEIGHT_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{x: rsp_out_x, y: rsp_out_y, value: rsp_edge_value, last: rsp_last_of_frame};
            if (edge_results_due.size() == 0) begin
               log_failure("result beat with nothing due", '0, got);
            end else begin
               want = edge_results_due.pop_front();
               if (got !== want) log_failure("edge result mismatch", want, got);
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_FRAME_WIDTH: cfg_width = csr_data;
               CSR_FRAME_HEIGHT: cfg_height = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) filter_pixel(req_pixel, req_frame_start);
      end
      pending = edge_results_due.size();
   end

endmodule

>>> test/tb_top.sv
// testbench top of the laplacian edge filter: clock, reset, pixel stimulus, backpressure, verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lef_pkg::*;

   localparam logic [IDX_BITS-1:0] CSR_SPARE_LO = IDX_BITS'(2);
   localparam logic [IDX_BITS-1:0] CSR_SPARE_HI = IDX_BITS'(3);
   localparam int IDLE_PCT     = 24;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 440;
   localparam int SETTLE       = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   pix_type             req_pixel = '0;
   logic                req_frame_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [COL_BITS-1:0] rsp_out_x;
   logic [ROW_BITS-1:0] rsp_out_y;
   logic [PIX_BITS-1:0] rsp_edge_value;
   logic                rsp_last_of_frame;
   logic                csr_write_en = 1'b0;
   logic [IDX_BITS-1:0] csr_index = '0;
   logic [CSR_BITS-1:0] csr_data = '0;

   int failures;
   int pending;

   bit calm = 1'b0;
   bit hold_wanted = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;

   // clamp-high, clamp-low (implicit next frame) and an in-range kernel, all 3x3
   pix_type corner_cases [27] = '{
      8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
      8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255,
      8'd0,   8'd110, 8'd0,   8'd130, 8'd100, 8'd90,  8'd0,   8'd120, 8'd0
   };

   laplacian_edge_filter dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_pixel, .req_frame_start,
      .rsp_valid, .rsp_stall, .rsp_out_x, .rsp_out_y, .rsp_edge_value, .rsp_last_of_frame,
      .csr_write_en, .csr_index, .csr_data
   );

   lef_checker edge_check (
      .clock, .reset,
      .req_valid, .req_stall, .req_pixel, .req_frame_start,
      .rsp_valid, .rsp_stall, .rsp_out_x, .rsp_out_y, .rsp_edge_value, .rsp_last_of_frame,
      .csr_write_en, .csr_index, .csr_data,
      .failures, .pending
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // receiver: random stall, one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_taken) begin
            hold_left = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   function automatic pix_type rand_pixel();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CSR_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_pixel(input pix_type px, input logic fs);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      req_frame_start <= fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic stream(input int count, input int frame_len, input bit first_start,
                         input bit noisy);
      logic fs;
      for (int i = 0; i < count; i++) begin
         if (i == 0) fs = first_start;
         else if (i % frame_len == 0) fs = ($urandom_range(0, 3) != 0);
         else fs = noisy && ($urandom_range(0, 149) == 0);
         send_pixel(rand_pixel(), fs);
      end
   endtask

   // sender waits until every due result is out, then lets the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   initial begin : stimulus
      int random_sent;
      int phase;
      int w_reg, h_reg, w_eff, h_eff, frames, count;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset sizes: two lines and a few pixels give the first results of row one
      stream(2 * 160 + 5, 160 * 120, 1'b1, 1'b0);
      drain();

      write_reg(CSR_FRAME_WIDTH, CSR_BITS'(3));
      write_reg(CSR_FRAME_HEIGHT, CSR_BITS'(3));
      for (int i = 0; i < 27; i++) send_pixel(corner_cases[i], i == 0 || i == 18);
      drain();

      // sizes below the minimum act as three
      write_reg(CSR_FRAME_WIDTH, '0);
      write_reg(CSR_FRAME_HEIGHT, '0);
      stream(18, 9, 1'b1, 1'b0);
      drain();
      write_reg(CSR_SPARE_LO, '1);
      write_reg(CSR_SPARE_HI, '1);
      stream(9, 9, 1'b1, 1'b0);
      drain();

      // shrink width with the column past the new width, then shrink height
      write_reg(CSR_FRAME_WIDTH, CSR_BITS'(16));
      write_reg(CSR_FRAME_HEIGHT, CSR_BITS'(10));
      stream(3 * 16 + 10, 1000, 1'b1, 1'b0);
      drain();
      write_reg(CSR_FRAME_WIDTH, CSR_BITS'(6));
      stream(40, 1000, 1'b0, 1'b0);
      drain();
      write_reg(CSR_FRAME_HEIGHT, CSR_BITS'(3));
      stream(30, 1000, 1'b0, 1'b0);
      drain();

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS || phase < 5) begin
         w_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
         h_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
         frames = $urandom_range(1, 3);
         // hold-off and no-idle phases use one full frame
         if (phase == 2 || phase == 4) begin
            w_reg = 10;
            h_reg = 10;
            frames = 1;
         end
         w_eff = (w_reg < 3) ? 3 : w_reg;
         h_eff = (h_reg < 3) ? 3 : h_reg;
         write_reg(CSR_FRAME_WIDTH, CSR_BITS'(w_reg));
         write_reg(CSR_FRAME_HEIGHT, CSR_BITS'(h_reg));
         count = frames * w_eff * h_eff;
         // a few truncated frames
         if (phase != 2 && phase != 4 && $urandom_range(0, 4) == 0) begin
            count = $urandom_range(1, count);
         end
         calm = (phase == 4);
         if (phase == 2) hold_wanted = 1'b1;
         stream(count, w_eff * h_eff, 1'b1, $urandom_range(0, 3) == 0);
         drain();
         calm = 1'b0;
         random_sent += count;
         phase++;
      end

      drain();
      repeat (20) @(negedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/lef_pkg.sv
hdl/lef_ram.sv
hdl/lef_position.sv
hdl/lef_kernel.sv
hdl/laplacian_edge_filter.sv
test/lef_checker.sv
test/tb_top.sv
